### hdl/jac_pkg.sv
// ----------------------------------------------------------------------------
// Jacobian package
// Types, constants and fixed-point helpers shared by the arm Jacobian block.
// ----------------------------------------------------------------------------
package jac_pkg;

	localparam int ANGLE_BITS      = 16;
	localparam int ENTRY_FRAC_BITS = 16;
	localparam int FIN_SHIFT       = 24 - ENTRY_FRAC_BITS;

	localparam int CORDIC_STEPS    = 24;
	localparam int STEPS_PER_STAGE = 4;
	localparam int CORDIC_STAGES   = CORDIC_STEPS / STEPS_PER_STAGE;
	localparam int CORDIC_LAT      = CORDIC_STAGES + 2;
	localparam int DP_LAT          = 5;
	localparam int PIPE_DEPTH      = 1 + CORDIC_LAT + DP_LAT;

	localparam int N_LANES = 8;
	localparam int N_ROWS  = 6;

	typedef logic signed [31:0] wk_t;
	typedef logic signed [33:0] cw_t;
	typedef logic signed [17:0] reg_t;
	typedef logic signed [19:0] entry_t;
	typedef entry_t [N_ROWS-1:0][N_ROWS-1:0] mat_t;

	localparam wk_t WORK_ONE  = 32'sd16777216;
	localparam wk_t ENTRY_MAX = 32'sd524287;
	localparam wk_t ENTRY_MIN = -32'sd524288;
	localparam wk_t ROUND_ADD = (FIN_SHIFT > 0) ? wk_t'(1 << (FIN_SHIFT - 1)) : 32'sd0;
	localparam cw_t GAIN_INV  = 34'sd652032874;

	localparam cw_t ATAN_TURNS [CORDIC_STEPS] = '{
		34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
		34'sd42667331, 34'sd21354465, 34'sd10680862, 34'sd5340245,
		34'sd2670163, 34'sd1335087, 34'sd667544, 34'sd333772,
		34'sd166886, 34'sd83443, 34'sd41722, 34'sd20861,
		34'sd10430, 34'sd5215, 34'sd2608, 34'sd1304,
		34'sd652, 34'sd326, 34'sd163, 34'sd81
	};

	localparam logic [2:0] REG_A2 = 3'd0;
	localparam logic [2:0] REG_A3 = 3'd1;
	localparam logic [2:0] REG_D3 = 3'd2;
	localparam logic [2:0] REG_D4 = 3'd3;
	localparam logic [2:0] REG_D5 = 3'd4;
	localparam logic [2:0] LAST_ROW_IDX = 3'd5;

	localparam int LANE_T1   = 0;
	localparam int LANE_T2   = 1;
	localparam int LANE_T4   = 2;
	localparam int LANE_T5   = 3;
	localparam int LANE_T23  = 4;
	localparam int LANE_T234 = 5;
	localparam int LANE_TP   = 6;
	localparam int LANE_TM   = 7;

	typedef struct packed {
		logic signed [15:0] angle_joint1;
		logic signed [15:0] angle_joint2;
		logic signed [15:0] angle_joint3;
		logic signed [15:0] angle_joint4;
		logic signed [15:0] angle_joint5;
		logic signed [15:0] angle_joint6;
	} angles_t;

	typedef struct packed {
		logic [2:0] row_index;
		entry_t     entry_joint1;
		entry_t     entry_joint2;
		entry_t     entry_joint3;
		entry_t     entry_joint4;
		entry_t     entry_joint5;
		entry_t     entry_joint6;
		logic       last_row;
	} row_t;

	typedef struct packed {
		reg_t a2;
		reg_t a3;
		reg_t d3;
		reg_t d4;
		reg_t d5;
	} links_t;

	typedef struct packed {
		wk_t s1, c1, s2, c2, s4, c4, s5, c5, s23, c23, s234, c234, sp, sm;
	} trig_t;

	function automatic wk_t mq(wk_t a, wk_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd8388608;
		return p[55:24];
	endfunction

	function automatic wk_t mh(wk_t a, wk_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b) + 64'sd16777216;
		return p[56:25];
	endfunction

	function automatic wk_t half(wk_t x);
		return (x + 32'sd1) >>> 1;
	endfunction

	function automatic wk_t reg_q24(reg_t r);
		return {{6{r[17]}}, r, 8'h00};
	endfunction

	function automatic entry_t fin(wk_t v);
		wk_t r;
		r = (v + ROUND_ADD) >>> FIN_SHIFT;
		if (r > ENTRY_MAX) begin
			r = ENTRY_MAX;
		end else if (r < ENTRY_MIN) begin
			r = ENTRY_MIN;
		end
		return r[19:0];
	endfunction

endpackage

### hdl/jac_cordic.sv
// ----------------------------------------------------------------------------
// Jacobian sine and cosine unit
// Pipelined rotation-mode CORDIC with quadrant folding, four steps per stage.
// ----------------------------------------------------------------------------
module jac_cordic import jac_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] turn,
	output wk_t         sin,
	output wk_t         cos
);

	cw_t  x_s [CORDIC_STAGES+1];
	cw_t  y_s [CORDIC_STAGES+1];
	cw_t  z_s [CORDIC_STAGES+1];
	logic flip_s [CORDIC_STAGES+1];

	logic        flip_in;
	logic [31:0] fold;
	cw_t         xr, yr;

	assign flip_in = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
	assign fold    = flip_in ? (turn - 32'h8000_0000) : turn;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= GAIN_INV;
			y_s[0]    <= '0;
			z_s[0]    <= {{2{fold[31]}}, fold};
			flip_s[0] <= flip_in;
		end
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_stage
		cw_t nx, ny, nz;

		always_comb begin
			cw_t xt, yt, zt, dx, dy;
			xt = x_s[k];
			yt = y_s[k];
			zt = z_s[k];
			for (int i = 0; i < STEPS_PER_STAGE; i++) begin
				dx = yt >>> (k * STEPS_PER_STAGE + i);
				dy = xt >>> (k * STEPS_PER_STAGE + i);
				if (zt >= 0) begin
					xt = xt - dx;
					yt = yt + dy;
					zt = zt - ATAN_TURNS[k * STEPS_PER_STAGE + i];
				end else begin
					xt = xt + dx;
					yt = yt - dy;
					zt = zt + ATAN_TURNS[k * STEPS_PER_STAGE + i];
				end
			end
			nx = xt;
			ny = yt;
			nz = zt;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1]    <= nx;
				y_s[k+1]    <= ny;
				z_s[k+1]    <= nz;
				flip_s[k+1] <= flip_s[k];
			end
		end
	end

	assign xr = (x_s[CORDIC_STAGES] + 34'sd32) >>> 6;
	assign yr = (y_s[CORDIC_STAGES] + 34'sd32) >>> 6;

	always_ff @(posedge clk) begin
		if (en) begin
			cos <= flip_s[CORDIC_STAGES] ? -wk_t'(xr) : wk_t'(xr);
			sin <= flip_s[CORDIC_STAGES] ? -wk_t'(yr) : wk_t'(yr);
		end
	end

endmodule

### hdl/jac_datapath.sv
// ----------------------------------------------------------------------------
// Jacobian entry datapath
// Five pipeline stages of products and sums that form the 36 matrix entries,
// ending in rounding and saturation to the output format.
// ----------------------------------------------------------------------------
module jac_datapath import jac_pkg::*; (
	input  logic   clk,
	input  logic   en,
	input  trig_t  trig,
	input  links_t links,
	output mat_t   mat_s5
);

	wk_t a2, a3, d3, d4, d5;

	assign a2 = reg_q24(links.a2);
	assign a3 = reg_q24(links.a3);
	assign d3 = reg_q24(links.d3);
	assign d4 = reg_q24(links.d4);
	assign d5 = reg_q24(links.d5);

	wk_t c1c5_s1, c234s1_s1, c5s1_s1, c234c1_s1, d3c1_s1, d4c1_s1, a3c23_s1, a2c2_s1;
	wk_t d5s234_s1, d3s1_s1, d4s1_s1, a2c1_s1, a3s23_s1, a2s2_s1, s23s4_s1, c23c4_s1;
	wk_t d5s5_s1, c23s4_s1, s23c4_s1, mhsp_s1, mhsm_s1, d5c234_s1, s234s5_s1;
	wk_t d5c1_s1, d5s1_s1, s234c1_s1, s234s1_s1, hs1_s1, hs2_s1;
	wk_t c1_s1, s1_s1, c5_s1, s5_s1, c2_s1, c234_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			c1c5_s1   <= mq(trig.c1, trig.c5);
			c234s1_s1 <= mq(trig.c234, trig.s1);
			c5s1_s1   <= mq(trig.c5, trig.s1);
			c234c1_s1 <= mq(trig.c234, trig.c1);
			d3c1_s1   <= mq(d3, trig.c1);
			d4c1_s1   <= mq(d4, trig.c1);
			a3c23_s1  <= mq(a3, trig.c23);
			a2c2_s1   <= mq(a2, trig.c2);
			d5s234_s1 <= mq(d5, trig.s234);
			d3s1_s1   <= mq(d3, trig.s1);
			d4s1_s1   <= mq(d4, trig.s1);
			a2c1_s1   <= mq(a2, trig.c1);
			a3s23_s1  <= mq(a3, trig.s23);
			a2s2_s1   <= mq(a2, trig.s2);
			s23s4_s1  <= mq(trig.s23, trig.s4);
			c23c4_s1  <= mq(trig.c23, trig.c4);
			d5s5_s1   <= mq(d5, trig.s5);
			c23s4_s1  <= mq(trig.c23, trig.s4);
			s23c4_s1  <= mq(trig.s23, trig.c4);
			mhsp_s1   <= mh(d5, trig.sp);
			mhsm_s1   <= mh(d5, trig.sm);
			d5c234_s1 <= mq(d5, trig.c234);
			s234s5_s1 <= mq(trig.s234, trig.s5);
			d5c1_s1   <= mq(d5, trig.c1);
			d5s1_s1   <= mq(d5, trig.s1);
			s234c1_s1 <= mq(trig.s234, trig.c1);
			s234s1_s1 <= mq(trig.s234, trig.s1);
			hs1_s1    <= half(trig.sm) + trig.s234 - half(trig.sp);
			hs2_s1    <= half(trig.sm) + half(trig.sp);
			c1_s1     <= trig.c1;
			s1_s1     <= trig.s1;
			c5_s1     <= trig.c5;
			s5_s1     <= trig.s5;
			c2_s1     <= trig.c2;
			c234_s1   <= trig.c234;
		end
	end

	wk_t ta_s2, tb_s2, tc_s2, td_s2, te_s2, tf_s2, tg_s2, th_s2, ti_s2, tj_s2, tk_s2;
	wk_t tl_s2, tm_s2, tn_s2, t5o_s2, j03_s2, j13_s2, j23_s2, j24_s2, z2_s2, z3_s2;
	wk_t c1c5_s2, c5s1_s2, d3c1_s2, d4c1_s2, d3s1_s2, d4s1_s2, a3s23_s2, a2s2_s2;
	wk_t d5c234_s2, s234c1_s2, s234s1_s2, s234s5_s2, c234_s2, c1_s2, s1_s2, c5_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			ta_s2     <= mq(c234s1_s1, s5_s1);
			tb_s2     <= mq(c234c1_s1, s5_s1);
			tc_s2     <= mq(a3c23_s1, s1_s1);
			td_s2     <= mq(a2c2_s1, s1_s1);
			te_s2     <= mq(d5s234_s1, s1_s1);
			tf_s2     <= mq(a3c23_s1, c1_s1);
			tg_s2     <= mq(a2c1_s1, c2_s1);
			th_s2     <= mq(d5s234_s1, c1_s1);
			ti_s2     <= mq(d5, s23s4_s1 - c23c4_s1);
			tj_s2     <= mq(d5s5_s1, c23s4_s1 + s23c4_s1);
			tk_s2     <= mq(d5s234_s1, s5_s1);
			tl_s2     <= mq(d5s1_s1, s5_s1);
			tm_s2     <= mq(d5c234_s1, c1_s1);
			tn_s2     <= mq(d5c1_s1, s5_s1);
			t5o_s2    <= mq(d5c234_s1, c5_s1);
			j03_s2    <= mq(d5c1_s1, c234_s1 + s234s5_s1);
			j13_s2    <= mq(d5s1_s1, c234_s1 + s234s5_s1);
			j23_s2    <= mq(d5, hs1_s1);
			j24_s2    <= -mq(d5, hs2_s1);
			z2_s2     <= a3c23_s1 - mhsp_s1 + a2c2_s1 + mhsm_s1 + d5s234_s1;
			z3_s2     <= a3c23_s1 - mhsp_s1 + mhsm_s1 + d5s234_s1;
			c1c5_s2   <= c1c5_s1;
			c5s1_s2   <= c5s1_s1;
			d3c1_s2   <= d3c1_s1;
			d4c1_s2   <= d4c1_s1;
			d3s1_s2   <= d3s1_s1;
			d4s1_s2   <= d4s1_s1;
			a3s23_s2  <= a3s23_s1;
			a2s2_s2   <= a2s2_s1;
			d5c234_s2 <= d5c234_s1;
			s234c1_s2 <= s234c1_s1;
			s234s1_s2 <= s234s1_s1;
			s234s5_s2 <= s234s5_s1;
			c234_s2   <= c234_s1;
			c1_s2     <= c1_s1;
			s1_s2     <= s1_s1;
			c5_s2     <= c5_s1;
		end
	end

	wk_t u1_s3, u2_s3, p_s3, q_s3, sx_s3, sy_s3, tmc_s3, tos_s3;
	wk_t tl_s3, tn_s3, j03_s3, j13_s3, j23_s3, j24_s3, z2_s3, z3_s3;
	wk_t s234c1_s3, s234s1_s3, s234s5_s3, c234_s3, c1_s3, s1_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			u1_s3     <= c1c5_s2 + ta_s2;
			u2_s3     <= c5s1_s2 - tb_s2;
			p_s3      <= a3s23_s2 + a2s2_s2 + ti_s2 - tj_s2;
			q_s3      <= d5c234_s2 - a3s23_s2 + tk_s2;
			sx_s3     <= d3c1_s2 + d4c1_s2 - tc_s2 - td_s2 - te_s2;
			sy_s3     <= d3s1_s2 + d4s1_s2 + tf_s2 + tg_s2 + th_s2;
			tmc_s3    <= mq(tm_s2, c5_s2);
			tos_s3    <= mq(t5o_s2, s1_s2);
			tl_s3     <= tl_s2;
			tn_s3     <= tn_s2;
			j03_s3    <= j03_s2;
			j13_s3    <= j13_s2;
			j23_s3    <= j23_s2;
			j24_s3    <= j24_s2;
			z2_s3     <= z2_s2;
			z3_s3     <= z3_s2;
			s234c1_s3 <= s234c1_s2;
			s234s1_s3 <= s234s1_s2;
			s234s5_s3 <= s234s5_s2;
			c234_s3   <= c234_s2;
			c1_s3     <= c1_s2;
			s1_s3     <= s1_s2;
		end
	end

	wk_t raw_s4 [N_ROWS][N_ROWS];

	always_ff @(posedge clk) begin
		if (en) begin
			raw_s4[0][0] <= mq(d5, u1_s3) + sx_s3;
			raw_s4[1][0] <= mq(d5, u2_s3) + sy_s3;
			raw_s4[2][0] <= '0;
			raw_s4[3][0] <= '0;
			raw_s4[4][0] <= '0;
			raw_s4[5][0] <= WORK_ONE;

			raw_s4[0][1] <= -mq(c1_s3, p_s3);
			raw_s4[1][1] <= -mq(s1_s3, p_s3);
			raw_s4[2][1] <= z2_s3;
			raw_s4[3][1] <= s1_s3;
			raw_s4[4][1] <= -c1_s3;
			raw_s4[5][1] <= '0;

			raw_s4[0][2] <= mq(c1_s3, q_s3);
			raw_s4[1][2] <= mq(s1_s3, q_s3);
			raw_s4[2][2] <= z3_s3;
			raw_s4[3][2] <= s1_s3;
			raw_s4[4][2] <= -c1_s3;
			raw_s4[5][2] <= '0;

			raw_s4[0][3] <= j03_s3;
			raw_s4[1][3] <= j13_s3;
			raw_s4[2][3] <= j23_s3;
			raw_s4[3][3] <= s1_s3;
			raw_s4[4][3] <= -c1_s3;
			raw_s4[5][3] <= '0;

			raw_s4[0][4] <= -tl_s3 - tmc_s3;
			raw_s4[1][4] <= tn_s3 - tos_s3;
			raw_s4[2][4] <= j24_s3;
			raw_s4[3][4] <= s234c1_s3;
			raw_s4[4][4] <= s234s1_s3;
			raw_s4[5][4] <= -c234_s3;

			raw_s4[0][5] <= '0;
			raw_s4[1][5] <= '0;
			raw_s4[2][5] <= '0;
			raw_s4[3][5] <= u2_s3;
			raw_s4[4][5] <= -u1_s3;
			raw_s4[5][5] <= -s234s5_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < N_ROWS; r++) begin
				for (int c = 0; c < N_ROWS; c++) begin
					mat_s5[r][c] <= fin(raw_s4[r][c]);
				end
			end
		end
	end

endmodule

### hdl/six_joint_arm_jacobian_top.sv
// ----------------------------------------------------------------------------
// Six-joint arm Jacobian, top level
// Turns one beat of joint angles into six beats, one per Jacobian row.
// ----------------------------------------------------------------------------
// The first row of an item is shown from the output register once the item
// leaves the last pipeline stage; the six rows follow on consecutive cycles
// when the receiver does not stall. The single row channel (six rows per item)
// sets the sustained rate; the pipeline (one angle-sum stage, eight CORDIC
// stages in eight parallel lanes, five product stages) keeps taking new angle
// beats while the previous item's rows are delivered, and stalls as one piece.
module six_joint_arm_jacobian_top import jac_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        angle_valid,
	output logic        angle_stall,
	input  angles_t     angle,
	output logic        row_valid,
	input  logic        row_stall,
	output row_t        row,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);

	links_t links_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			links_q.a2 <= -18'sd27853;
			links_q.a3 <= -18'sd25703;
			links_q.d3 <= 18'sd0;
			links_q.d4 <= 18'sd8736;
			links_q.d5 <= 18'sd6534;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_A2: links_q.a2 <= cfg_data;
				REG_A3: links_q.a3 <= cfg_data;
				REG_D3: links_q.d3 <= cfg_data;
				REG_D4: links_q.d4 <= cfg_data;
				REG_D5: links_q.d5 <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [PIPE_DEPTH-1:0] stage_vld_q;
	logic                  adv, out_free, take, load;
	logic [2:0]            row_q;
	logic                  out_vld_q;
	mat_t                  mat_q;
	mat_t                  mat_s5;

	assign take        = out_vld_q && !row_stall;
	assign out_free    = !out_vld_q || (take && (row_q == LAST_ROW_IDX));
	assign adv         = !stage_vld_q[PIPE_DEPTH-1] || out_free;
	assign load        = adv && stage_vld_q[PIPE_DEPTH-1];
	assign angle_stall = !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (adv) begin
			stage_vld_q <= {stage_vld_q[PIPE_DEPTH-2:0], angle_valid};
		end
	end

	logic [31:0] t1, t2, t3, t4, t5, t23, t234;
	logic [31:0] turn_s1 [N_LANES];

	assign t1   = {angle.angle_joint1[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
	assign t2   = {angle.angle_joint2[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
	assign t3   = {angle.angle_joint3[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
	assign t4   = {angle.angle_joint4[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
	assign t5   = {angle.angle_joint5[ANGLE_BITS-1:0], {(32-ANGLE_BITS){1'b0}}};
	assign t23  = t2 + t3;
	assign t234 = t23 + t4;

	always_ff @(posedge clk) begin
		if (adv) begin
			turn_s1[LANE_T1]   <= t1;
			turn_s1[LANE_T2]   <= t2;
			turn_s1[LANE_T4]   <= t4;
			turn_s1[LANE_T5]   <= t5;
			turn_s1[LANE_T23]  <= t23;
			turn_s1[LANE_T234] <= t234;
			turn_s1[LANE_TP]   <= t234 + t5;
			turn_s1[LANE_TM]   <= t234 - t5;
		end
	end

	wk_t   sin_l [N_LANES];
	wk_t   cos_l [N_LANES];
	trig_t trig;

	for (genvar l = 0; l < N_LANES; l++) begin : g_lane
		jac_cordic u_cordic (
			.clk  (clk),
			.en   (adv),
			.turn (turn_s1[l]),
			.sin  (sin_l[l]),
			.cos  (cos_l[l])
		);
	end

	assign trig.s1   = sin_l[LANE_T1];
	assign trig.c1   = cos_l[LANE_T1];
	assign trig.s2   = sin_l[LANE_T2];
	assign trig.c2   = cos_l[LANE_T2];
	assign trig.s4   = sin_l[LANE_T4];
	assign trig.c4   = cos_l[LANE_T4];
	assign trig.s5   = sin_l[LANE_T5];
	assign trig.c5   = cos_l[LANE_T5];
	assign trig.s23  = sin_l[LANE_T23];
	assign trig.c23  = cos_l[LANE_T23];
	assign trig.s234 = sin_l[LANE_T234];
	assign trig.c234 = cos_l[LANE_T234];
	assign trig.sp   = sin_l[LANE_TP];
	assign trig.sm   = sin_l[LANE_TM];

	jac_datapath u_datapath (
		.clk    (clk),
		.en     (adv),
		.trig   (trig),
		.links  (links_q),
		.mat_s5 (mat_s5)
	);

	always_ff @(posedge clk) begin
		if (load) begin
			mat_q <= mat_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			row_q     <= '0;
		end else if (load) begin
			out_vld_q <= 1'b1;
			row_q     <= '0;
		end else if (take) begin
			if (row_q == LAST_ROW_IDX) begin
				out_vld_q <= 1'b0;
				row_q     <= '0;
			end else begin
				row_q <= row_q + 3'd1;
			end
		end
	end

	assign row_valid          = out_vld_q;
	assign row.row_index      = row_q;
	assign row.entry_joint1   = mat_q[row_q][0];
	assign row.entry_joint2   = mat_q[row_q][1];
	assign row.entry_joint3   = mat_q[row_q][2];
	assign row.entry_joint4   = mat_q[row_q][3];
	assign row.entry_joint5   = mat_q[row_q][4];
	assign row.entry_joint6   = mat_q[row_q][5];
	assign row.last_row       = (row_q == LAST_ROW_IDX);

`ifndef SYNTH
	a_row_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(take && row_q != LAST_ROW_IDX) |=> (row_valid && row_q == $past(row_q) + 3'd1))
		else $error("row counter did not advance after a beat");

	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_vld_q[PIPE_DEPTH-1] && out_vld_q && row_stall) |-> angle_stall)
		else $error("pipeline advanced while its last stage could not drain");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> (row_q <= LAST_ROW_IDX))
		else $error("row index out of range");
`endif

endmodule
